// ===== rtl/bsdc_pkg.sv =====
// Package: shared types and constants of the beam-synced display coprocessor.
package bsdc_pkg;

  // Engine run modes
  localparam logic [2:0] MODE_STOPPED = 3'd0;
  localparam logic [2:0] MODE_FETCH1  = 3'd1;
  localparam logic [2:0] MODE_FETCH2  = 3'd2;
  localparam logic [2:0] MODE_WAITING = 3'd3;
  localparam logic [2:0] MODE_WAKE    = 3'd4;

  // Register offsets owned by this block
  localparam logic [8:0] OFF_COPCON = 9'h02E;
  localparam logic [8:0] OFF_LC1H   = 9'h080;
  localparam logic [8:0] OFF_LC1L   = 9'h082;
  localparam logic [8:0] OFF_LC2H   = 9'h084;
  localparam logic [8:0] OFF_LC2L   = 9'h086;
  localparam logic [8:0] OFF_JMP1   = 9'h088;
  localparam logic [8:0] OFF_JMP2   = 9'h08A;

  // Move protection limits
  localparam logic [8:0] MOVE_DANGER_LO = 9'h040;
  localparam logic [8:0] MOVE_FREE_LO   = 9'h080;

  // Opcode of an input item
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_HOST = 1'b1;

  // One input item
  typedef struct packed {
    logic        opcode;
    logic [7:0]  beam_v;
    logic [7:0]  beam_h;
    logic        dma_on;
    logic [15:0] fetch_word;
    logic [8:0]  reg_offset;
    logic [15:0] reg_value;
  } item_t;

  // Result fields that do not depend on the address width
  typedef struct packed {
    logic        write_valid;
    logic [8:0]  write_offset;
    logic [15:0] write_data;
    logic [2:0]  mode_now;
    logic        write_accepted;
  } res_t;

endpackage

// ===== rtl/bsdc_step.sv =====
// Single-step update of the coprocessor state for one item.
module bsdc_step #(
  parameter int ADDRESS_BITS = 19
) (
  input  bsdc_pkg::item_t          item,
  input  logic                     danger,
  input  logic [ADDRESS_BITS-1:0]  pc,
  input  logic [ADDRESS_BITS-1:0]  lp1,
  input  logic [ADDRESS_BITS-1:0]  lp2,
  input  logic [15:0]              fw1,
  input  logic [15:0]              sw,
  input  logic [2:0]               mode,
  output logic                     danger_next,
  output logic [ADDRESS_BITS-1:0]  pc_next,
  output logic [ADDRESS_BITS-1:0]  lp1_next,
  output logic [ADDRESS_BITS-1:0]  lp2_next,
  output logic [15:0]              fw1_next,
  output logic [15:0]              sw_next,
  output logic [2:0]               mode_next,
  output bsdc_pkg::res_t           res
);
  import bsdc_pkg::*;

  logic [15:0] sw_sel;
  logic [7:0]  vmask;
  logic [7:0]  hmask;
  logic [15:0] target;
  logic [15:0] beam;
  logic        beam_pass;
  logic [8:0]  move_off;
  logic        move_ok;
  logic        active;
  logic        ow_en;
  logic [8:0]  ow_off;
  logic [15:0] ow_val;
  logic        ow_hit;

  // Beam compare: the second word is the one just fetched in FETCH2
  assign sw_sel    = (mode == MODE_FETCH2) ? item.fetch_word : sw;
  assign vmask     = {1'b1, sw_sel[14:8]};
  assign hmask     = sw_sel[7:0] & 8'hFE;
  assign target    = {fw1[15:8] & vmask, fw1[7:0] & hmask};
  assign beam      = {item.beam_v & vmask, item.beam_h & 8'hFE & hmask};
  assign beam_pass = (beam >= target);

  // Move target and protection check
  assign move_off = {fw1[8:1], 1'b0};
  assign move_ok  = (move_off >= MOVE_DANGER_LO) && ((move_off >= MOVE_FREE_LO) || danger);

  // Engine runs on even color clocks with DMA on
  assign active = (item.opcode == OP_TICK) && item.dma_on && !item.beam_h[0];

  always_comb begin
    danger_next = danger;
    pc_next     = pc;
    lp1_next    = lp1;
    lp2_next    = lp2;
    fw1_next    = fw1;
    sw_next     = sw;
    mode_next   = mode;
    res         = '0;
    ow_en       = 1'b0;
    ow_off      = '0;
    ow_val      = '0;
    ow_hit      = 1'b0;

    // Fetch / wait sequencing
    if (item.opcode == OP_HOST) begin
      ow_en  = 1'b1;
      ow_off = item.reg_offset;
      ow_val = item.reg_value;
    end else if (active) begin
      unique case (mode)
        MODE_FETCH1: begin
          fw1_next  = item.fetch_word;
          pc_next   = pc + ADDRESS_BITS'(2);
          mode_next = MODE_FETCH2;
        end
        MODE_FETCH2: begin
          sw_next = item.fetch_word;
          pc_next = pc + ADDRESS_BITS'(2);
          if (!fw1[0]) begin
            if (!move_ok) begin
              mode_next = MODE_STOPPED;
            end else begin
              mode_next          = MODE_FETCH1;
              res.write_valid    = 1'b1;
              res.write_offset   = move_off;
              res.write_data     = item.fetch_word;
              ow_en              = 1'b1;
              ow_off             = move_off;
              ow_val             = item.fetch_word;
            end
          end else if (!item.fetch_word[0]) begin
            mode_next = MODE_WAITING;
          end else begin
            // skip: one more instruction pair past the current one
            if (beam_pass) pc_next = pc + ADDRESS_BITS'(6);
            mode_next = MODE_FETCH1;
          end
        end
        MODE_WAITING: begin
          if (beam_pass) mode_next = MODE_WAKE;
        end
        MODE_WAKE: begin
          mode_next = MODE_FETCH1;
        end
        default: begin
        end
      endcase
    end

    // Writes to this block's own registers (host or move)
    if (ow_en) begin
      ow_hit = 1'b1;
      unique case (ow_off)
        OFF_COPCON: danger_next = ow_val[1];
        OFF_LC1H:   lp1_next = {ow_val[ADDRESS_BITS-17:0], lp1[15:0]};
        OFF_LC1L:   lp1_next = {lp1[ADDRESS_BITS-1:16], ow_val};
        OFF_LC2H:   lp2_next = {ow_val[ADDRESS_BITS-17:0], lp2[15:0]};
        OFF_LC2L:   lp2_next = {lp2[ADDRESS_BITS-1:16], ow_val};
        OFF_JMP1: begin
          pc_next   = lp1;
          mode_next = MODE_FETCH1;
        end
        OFF_JMP2: begin
          pc_next   = lp2;
          mode_next = MODE_FETCH1;
        end
        default: ow_hit = 1'b0;
      endcase
    end

    res.mode_now       = mode_next;
    res.write_accepted = (item.opcode == OP_HOST) && ow_hit;
  end

endmodule

// ===== rtl/beam_synced_display_coprocessor_top.sv =====
// Top level of the beam-synced display-list coprocessor.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per beam color clock:
//   either a beam tick (opcode 0) with the fetched memory word, or a host
//   register write (opcode 1). Each item gives exactly one result on the
//   output channel (out_valid / out_stall): the MOVE write it issues, the
//   program counter and run mode after the step, and whether a host write
//   hit one of this block's registers.
//   The configuration channel (cfg_valid / cfg_ready) sets the danger bit;
//   cfg_ready drops while an item waits in the input register, and writes
//   are meant for when the block is idle.
//   An accepted item moves from the input register to the output register
//   once that is empty or taken. Throughput: one item per cycle while the
//   receiver does not stall, limited by the single input register.
//   Reset (rst, synchronous) clears pointers, counter, fetched words and the
//   danger bit and puts the engine in the stopped mode; both valids drop.
//   When the receiver stalls, the result holds and the item in the input
//   register waits; in_stall rises only once that register is also full.
module beam_synced_display_coprocessor_top #(
  parameter int ADDRESS_BITS = 19
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  beam_v,
  input  logic [7:0]  beam_h,
  input  logic        dma_on,
  input  logic [15:0] fetch_word,
  input  logic [8:0]  reg_offset,
  input  logic [15:0] reg_value,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [8:0]  write_offset,
  output logic [15:0] write_data,
  output logic [18:0] fetch_address,
  output logic [2:0]  mode_now,
  output logic        write_accepted
);
  import bsdc_pkg::*;

  // Engine state
  logic                    danger;
  logic [ADDRESS_BITS-1:0] pc;
  logic [ADDRESS_BITS-1:0] lp1;
  logic [ADDRESS_BITS-1:0] lp2;
  logic [15:0]             fw1;
  logic [15:0]             sw;
  logic [2:0]              mode;

  logic                    danger_next;
  logic [ADDRESS_BITS-1:0] pc_next;
  logic [ADDRESS_BITS-1:0] lp1_next;
  logic [ADDRESS_BITS-1:0] lp2_next;
  logic [15:0]             fw1_next;
  logic [15:0]             sw_next;
  logic [2:0]              mode_next;
  res_t                    res;

  // Input register
  logic  in_full;
  item_t item_q;
  item_t item_d;
  logic  advance;
  logic  in_take;
  logic [31:0] pc_wide;

  assign item_d = '{opcode: opcode, beam_v: beam_v, beam_h: beam_h, dma_on: dma_on,
                    fetch_word: fetch_word, reg_offset: reg_offset,
                    reg_value: reg_value};

  // Handshake: output register frees when empty or taken
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = !in_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q <= item_d;
    end
  end

  // Step logic
  bsdc_step #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_step (
    .item        (item_q),
    .danger      (danger),
    .pc          (pc),
    .lp1         (lp1),
    .lp2         (lp2),
    .fw1         (fw1),
    .sw          (sw),
    .mode        (mode),
    .danger_next (danger_next),
    .pc_next     (pc_next),
    .lp1_next    (lp1_next),
    .lp2_next    (lp2_next),
    .fw1_next    (fw1_next),
    .sw_next     (sw_next),
    .mode_next   (mode_next),
    .res         (res)
  );

  // State update on each processed item; config sets the danger bit
  always_ff @(posedge clk) begin
    if (rst) begin
      danger <= 1'b0;
      pc     <= '0;
      lp1    <= '0;
      lp2    <= '0;
      fw1    <= '0;
      sw     <= '0;
      mode   <= MODE_STOPPED;
    end else if (advance) begin
      danger <= danger_next;
      pc     <= pc_next;
      lp1    <= lp1_next;
      lp2    <= lp2_next;
      fw1    <= fw1_next;
      sw     <= sw_next;
      mode   <= mode_next;
    end else if (cfg_valid && cfg_ready) begin
      danger <= cfg_data;
    end
  end

  // Result register
  assign pc_wide = 32'(pc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_valid    <= res.write_valid;
      write_offset   <= res.write_offset;
      write_data     <= res.write_data;
      fetch_address  <= pc_wide[18:0];
      mode_now       <= res.mode_now;
      write_accepted <= res.write_accepted;
    end
  end

`ifndef SYNTHESIS
  // A move never reaches the always-protected low offsets
  a_move_protected: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> write_offset >= MOVE_DANGER_LO)
    else $error("move write to protected offset");

  // Moves come from ticks, accepted flags from host writes
  a_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(write_valid && write_accepted))
    else $error("write_valid and write_accepted both set");

  // The input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && in_full)
    else $error("input stalled without a held result");

  // A processed item shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the beam-synced display coprocessor: directed and random items, self-checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsdc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;

  // expected contents of one result item
  typedef struct {
    res_t        fields;
    logic [18:0] addr;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = 1'b0;
  logic [7:0]  beam_v = 8'h00;
  logic [7:0]  beam_h = 8'h00;
  logic        dma_on = 1'b0;
  logic [15:0] fetch_word = 16'h0000;
  logic [8:0]  reg_offset = 9'h000;
  logic [15:0] reg_value = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_valid;
  logic [8:0]  write_offset;
  logic [15:0] write_data;
  logic [18:0] fetch_address;
  logic [2:0]  mode_now;
  logic        write_accepted;

  beam_synced_display_coprocessor_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .beam_v(beam_v),
    .beam_h(beam_h),
    .dma_on(dma_on),
    .fetch_word(fetch_word),
    .reg_offset(reg_offset),
    .reg_value(reg_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .write_valid(write_valid),
    .write_offset(write_offset),
    .write_data(write_data),
    .fetch_address(fetch_address),
    .mode_now(mode_now),
    .write_accepted(write_accepted)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // coprocessor state as predicted
  logic [18:0] pc_m, lp1_m, lp2_m;
  logic [15:0] word1_m, word2_m;
  logic [2:0]  mode_m;
  logic        danger_m;

  step_result_t pending_results[$];
  int err_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  // writes to the block's own registers; returns whether the offset is one of them
  function automatic logic own_reg_write(logic [8:0] off, logic [15:0] val);
    case (off)
      OFF_COPCON: danger_m = val[1];
      OFF_LC1H:   lp1_m = {val[2:0], lp1_m[15:0]};
      OFF_LC1L:   lp1_m = {lp1_m[18:16], val};
      OFF_LC2H:   lp2_m = {val[2:0], lp2_m[15:0]};
      OFF_LC2L:   lp2_m = {lp2_m[18:16], val};
      OFF_JMP1: begin
        pc_m = lp1_m;
        mode_m = MODE_FETCH1;
      end
      OFF_JMP2: begin
        pc_m = lp2_m;
        mode_m = MODE_FETCH1;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // masked beam compare of WAIT and SKIP
  function automatic logic beam_match(logic [7:0] bv, logic [7:0] bh);
    logic [7:0]  vmask, hmask;
    logic [15:0] target, beam;
    vmask = {1'b1, word2_m[14:8]};
    hmask = word2_m[7:0] & 8'hFE;
    target = {word1_m[15:8] & vmask, word1_m[7:0] & hmask};
    beam = {bv & vmask, bh & hmask};
    return beam >= target;
  endfunction

  function automatic logic move_permitted(logic [8:0] off);
    if (off < MOVE_DANGER_LO) return 1'b0;
    return (off >= MOVE_FREE_LO) || danger_m;
  endfunction

  // one step of the coprocessor: updates the predicted state, gives the result
  function automatic void coproc_step(input item_t it, output step_result_t e);
    logic [8:0] target;
    e.fields = '0;
    if (it.opcode == OP_HOST) begin
      e.fields.write_accepted = own_reg_write(it.reg_offset, it.reg_value);
    end else if (it.dma_on && !it.beam_h[0]) begin
      case (mode_m)
        MODE_FETCH1: begin
          word1_m = it.fetch_word;
          pc_m = pc_m + 19'd2;
          mode_m = MODE_FETCH2;
        end
        MODE_FETCH2: begin
          word2_m = it.fetch_word;
          pc_m = pc_m + 19'd2;
          if (!word1_m[0]) begin
            target = word1_m[8:0] & 9'h1FE;
            if (!move_permitted(target)) begin
              mode_m = MODE_STOPPED;
            end else begin
              // mode first, so a jump strobe can redirect the engine
              mode_m = MODE_FETCH1;
              e.fields.write_valid = 1'b1;
              e.fields.write_offset = target;
              e.fields.write_data = word2_m;
              void'(own_reg_write(target, word2_m));
            end
          end else if (!word2_m[0]) begin
            mode_m = MODE_WAITING;
          end else begin
            if (beam_match(it.beam_v, it.beam_h)) pc_m = pc_m + 19'd4;
            mode_m = MODE_FETCH1;
          end
        end
        MODE_WAITING: if (beam_match(it.beam_v, it.beam_h)) mode_m = MODE_WAKE;
        MODE_WAKE: mode_m = MODE_FETCH1;
        default: ;
      endcase
    end
    e.fields.mode_now = mode_m;
    e.addr = pc_m;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    step_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 32'h0, 32'h0);
      end else begin
        e = pending_results.pop_front();
        if (write_valid !== e.fields.write_valid)
          report_mismatch("write_valid", 32'(e.fields.write_valid), 32'(write_valid));
        if (write_offset !== e.fields.write_offset)
          report_mismatch("write_offset", 32'(e.fields.write_offset), 32'(write_offset));
        if (write_data !== e.fields.write_data)
          report_mismatch("write_data", 32'(e.fields.write_data), 32'(write_data));
        if (fetch_address !== e.addr)
          report_mismatch("fetch_address", 32'(e.addr), 32'(fetch_address));
        if (mode_now !== e.fields.mode_now)
          report_mismatch("mode_now", 32'(e.fields.mode_now), 32'(mode_now));
        if (write_accepted !== e.fields.write_accepted)
          report_mismatch("write_accepted", 32'(e.fields.write_accepted),
                          32'(write_accepted));
      end
    end
  end

  // receiver stall: random, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("beam_synced_display_coprocessor_top test failed");
      $finish;
    end
  end

  // offer one item, wait until taken, then predict its result
  task automatic send_item(input item_t it);
    step_result_t e;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    opcode <= it.opcode;
    beam_v <= it.beam_v;
    beam_h <= it.beam_h;
    dma_on <= it.dma_on;
    fetch_word <= it.fetch_word;
    reg_offset <= it.reg_offset;
    reg_value <= it.reg_value;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    coproc_step(it, e);
    pending_results.push_back(e);
  endtask

  // stop offering and let every outstanding result drain
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_danger_cfg(input logic val);
    drain_results();
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    danger_m = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t noise_item();
    logic [63:0] raw;
    item_t it;
    raw = {$urandom, $urandom};
    it = raw[58:0];
    return it;
  endfunction

  function automatic item_t host_item(logic [8:0] off, logic [15:0] val);
    item_t it;
    it = noise_item();
    it.opcode = OP_HOST;
    it.reg_offset = off;
    it.reg_value = val;
    return it;
  endfunction

  function automatic item_t tick_item(logic [7:0] v, logic [7:0] h, logic dma, logic [15:0] word);
    item_t it;
    it = noise_item();
    it.opcode = OP_TICK;
    it.beam_v = v;
    it.beam_h = h;
    it.dma_on = dma;
    it.fetch_word = word;
    return it;
  endfunction

  function automatic logic [8:0] own_offset(int k);
    case (k)
      0: return OFF_COPCON;
      1: return OFF_LC1H;
      2: return OFF_LC1L;
      3: return OFF_LC2H;
      4: return OFF_LC2L;
      5: return OFF_JMP1;
      default: return OFF_JMP2;
    endcase
  endfunction

  // first instruction word: mostly legal moves, some protected ones, WAIT/SKIP
  function automatic logic [15:0] first_instruction_word();
    logic [15:0] w;
    logic [8:0]  off;
    w = 16'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: off = 9'($urandom_range(9'h080, 9'h1FF));
      4: off = 9'($urandom_range(9'h040, 9'h07F));
      5: off = 9'($urandom_range(9'h000, 9'h03F));
      6: off = own_offset($urandom_range(6));
      default: return {w[15:1], 1'b1};
    endcase
    return {w[15:9], off[8:1], 1'b0};
  endfunction

  // random item shaped by the predicted run mode
  function automatic item_t random_item();
    item_t it;
    int pick;
    it = noise_item();
    pick = $urandom_range(99);
    if (pick < 6) return it;
    if (pick < (mode_m == MODE_STOPPED ? 70 : 14)) begin
      it.opcode = OP_HOST;
      if ($urandom_range(7) != 0) it.reg_offset = own_offset($urandom_range(6));
      return it;
    end
    it.opcode = OP_TICK;
    it.dma_on = ($urandom_range(9) != 0);
    it.beam_h[0] = ($urandom_range(7) == 0);
    if (mode_m == MODE_FETCH1) it.fetch_word = first_instruction_word();
    return it;
  endfunction

  // pointer writes, unknown offsets, jumps, idle ticks, address wrap
  task automatic test_host_registers();
    send_item(host_item(OFF_LC1H, 16'hFFFF));
    send_item(host_item(OFF_LC1L, 16'hFFFF));
    send_item(host_item(9'h081, 16'hFFFF));
    send_item(host_item(9'h1FF, 16'h0000));
    send_item(host_item(OFF_LC2L, 16'h1000));
    send_item(host_item(OFF_JMP1, 16'h0000));
    send_item(tick_item(8'h00, 8'h00, 1'b0, 16'h0100));
    send_item(tick_item(8'hFF, 8'hFF, 1'b1, 16'h0100));
    send_item(tick_item(8'hFF, 8'hFE, 1'b1, 16'h0100));
  endtask

  // move protection with and without the danger bit, self move to a jump strobe
  task automatic test_move_protection();
    write_danger_cfg(1'b1);
    send_item(host_item(OFF_JMP2, 16'h0000));
    send_item(tick_item(8'h00, 8'h00, 1'b1, 16'h0040));
    send_item(tick_item(8'h00, 8'h02, 1'b1, 16'hFFFF));
    write_danger_cfg(1'b0);
    send_item(tick_item(8'h00, 8'h04, 1'b1, 16'h007E));
    send_item(tick_item(8'h00, 8'h06, 1'b1, 16'h1234));
    send_item(host_item(OFF_COPCON, 16'h0002));
    send_item(host_item(OFF_JMP2, 16'h0000));
    send_item(tick_item(8'h00, 8'h08, 1'b1, 16'hFE88));
    send_item(tick_item(8'h00, 8'h0A, 1'b1, 16'h5555));
    send_item(host_item(OFF_COPCON, 16'hFFFD));
    send_item(tick_item(8'h00, 8'h0C, 1'b1, 16'h0000));
    send_item(tick_item(8'h00, 8'h0E, 1'b1, 16'h0000));
  endtask

  // WAIT until the beam passes, then a SKIP that jumps
  task automatic test_wait_and_skip();
    send_item(host_item(OFF_JMP2, 16'h0000));
    send_item(tick_item(8'h00, 8'h00, 1'b1, 16'hFF01));
    send_item(tick_item(8'h00, 8'h02, 1'b1, 16'hFFFE));
    send_item(tick_item(8'h10, 8'hF0, 1'b1, 16'h0000));
    send_item(tick_item(8'hFF, 8'hFE, 1'b1, 16'h0000));
    send_item(tick_item(8'h00, 8'h00, 1'b1, 16'h0000));
    send_item(tick_item(8'h00, 8'h00, 1'b1, 16'h0001));
    send_item(tick_item(8'h00, 8'h00, 1'b1, 16'h0001));
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_toggle <= ~hold_toggle;
    repeat (30) send_item(random_item());
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input logic danger);
    write_danger_cfg(danger);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (220) send_item(random_item());
  endtask

  initial begin
    pc_m = '0;
    lp1_m = '0;
    lp2_m = '0;
    word1_m = '0;
    word2_m = '0;
    mode_m = MODE_STOPPED;
    danger_m = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_host_registers();
    test_move_protection();
    test_wait_and_skip();
    test_backpressure();
    test_random_traffic(32, 65, 1'b1);
    test_random_traffic(65, 32, 1'b0);
    test_random_traffic(0, 0, 1'b1);

    // final drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("beam_synced_display_coprocessor_top test passed");
    else
      $display("beam_synced_display_coprocessor_top test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bsdc_pkg.sv
rtl/bsdc_step.sv
rtl/beam_synced_display_coprocessor_top.sv
tb/tb_top.sv
